// File: design/tdph_pkg.sv
// ----------------------------------------------------------------------------
// tdph_pkg: shared definitions for the 2d position histogram unit
// stream layouts, register indexes, function codes and reset values
// ----------------------------------------------------------------------------
`default_nettype none

package tdph_pkg;

    // default sizes
    localparam int BINS_PER_AXIS_DEF = 256;
    localparam int COUNT_WIDTH_DEF   = 32;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_SCALE = 2'd2;

    localparam logic [31:0] RESET_ORIGIN = 32'hFFF4_0000;  // -12.0 in q15.16
    localparam logic [31:0] RESET_SCALE  = 32'h0064_0000;  // 100.0 in q16.16

    // function codes carried in the input tuser
    localparam logic FUNC_ACCUM = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // input tdata: x_coord, y_coord, read_row, read_col
    localparam int COORD_W    = 32;
    localparam int REQ_IDX_W  = 8;
    localparam int S_TDATA_W  = 80;

    // output tdata: bin_x, bin_y, bin_count
    localparam int OUT_IDX_W     = 8;
    localparam int OUT_COUNT_W   = 32;
    localparam int OUT_COUNT_LSB = 16;
    localparam int M_TDATA_W     = 48;

endpackage

`default_nettype wire

// File: design/two_d_position_histogram_unit.sv
// ----------------------------------------------------------------------------
// two_d_position_histogram_unit: uniform bin 2d histogram of positions
// bins q15.16 points into a square grid of saturating counts, reads back bins
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata x,y,row,col; tuser func
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata bin_x,bin_y,count; tuser in_range
//  cfg       in   i_cfg_we (no wait)             i_cfg_idx, i_cfg_data
//
//  each transaction runs through these steps: accept with origin subtract,
//  multiply by bin_scale, bin check and count memory read, then increment
//  and write back; one item is in flight at a time, as the read and the
//  write back share the single count memory
//  after reset the count memory is cleared one entry a cycle, all
//  BINS_PER_AXIS*BINS_PER_AXIS entries (65536 by default); s_axis_tready is
//  low during that pass, config writes are taken as usual
//  the result sits in an output register: a new transaction is accepted while
//  it waits, and the next one holds in its last step until m_axis_tready
// ----------------------------------------------------------------------------
`default_nettype none

module two_d_position_histogram_unit
    import tdph_pkg::*;
#(
    parameter int BINS_PER_AXIS = BINS_PER_AXIS_DEF,
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // x_coord[31:0], y_coord[63:32], read_row[71:64], read_col[79:72]
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // func[0]
    input  wire logic                  s_axis_tuser,

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // bin_x[7:0], bin_y[15:8], bin_count[47:16]
    output logic [M_TDATA_W-1:0]       m_axis_tdata,
    // in_range[0]
    output logic                       m_axis_tuser,

    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH  = BINS_PER_AXIS * BINS_PER_AXIS;
    localparam int IDX_W  = $clog2(BINS_PER_AXIS);
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_ADDR,
        S_DONE
    } t_state;

    // configuration registers
    logic [31:0] r_x_origin;
    logic [31:0] r_y_origin;
    logic [31:0] r_bin_scale;

    // control
    t_state              r_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic                r_out_valid;

    // item registers
    logic                r_func;
    logic [32:0]         r_dx;
    logic [32:0]         r_dy;
    logic [REQ_IDX_W-1:0] r_row;
    logic [REQ_IDX_W-1:0] r_col;
    logic [31:0]         r_px_hi;
    logic [31:0]         r_py_hi;
    logic                r_x_neg;
    logic                r_y_neg;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_ok;
    logic [OUT_IDX_W-1:0] r_bx;
    logic [OUT_IDX_W-1:0] r_by;
    logic [M_TDATA_W-1:0] r_out_data;
    logic                r_out_ok;

    // count memory
    logic [COUNT_WIDTH-1:0] r_mem [DEPTH];
    logic [COUNT_WIDTH-1:0] r_rd_data;

    logic                   w_accept;
    logic                   w_out_free;
    logic [COORD_W-1:0]     w_x;
    logic [COORD_W-1:0]     w_y;
    logic [32:0]            n_dx;
    logic [32:0]            n_dy;
    logic [63:0]            w_px;
    logic [63:0]            w_py;
    logic                   w_scale_zero;
    logic                   w_x_ok;
    logic                   w_y_ok;
    logic [IDX_W-1:0]       w_acc_ix;
    logic [IDX_W-1:0]       w_acc_iy;
    logic                   w_rd_ok;
    logic [IDX_W-1:0]       w_ix;
    logic [IDX_W-1:0]       w_iy;
    logic                   w_ok;
    logic [ADDR_W-1:0]      w_addr;
    logic [OUT_IDX_W-1:0]   n_bx;
    logic [OUT_IDX_W-1:0]   n_by;
    logic [COUNT_WIDTH-1:0] w_new_count;
    logic [COUNT_WIDTH-1:0] w_res_count;
    logic                   w_mem_we;
    logic [ADDR_W-1:0]      w_mem_waddr;
    logic [COUNT_WIDTH-1:0] w_mem_wdata;
    logic                   w_mem_re;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_ok;

    // origin subtract, exact in 33-bit signed
    assign w_x  = s_axis_tdata[COORD_W-1:0];
    assign w_y  = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign n_dx = {w_x[31], w_x} - {r_x_origin[31], r_x_origin};
    assign n_dy = {w_y[31], w_y} - {r_y_origin[31], r_y_origin};

    // scale multiply, the integer part of the q.32 product is the bin
    assign w_px = 64'(r_dx[31:0]) * 64'(r_bin_scale);
    assign w_py = 64'(r_dy[31:0]) * 64'(r_bin_scale);

    // bin check and address
    always_comb begin
        w_scale_zero = (r_bin_scale == 32'd0);
        // a point below the origin only lands in bin 0 when the scale is zero
        w_x_ok   = r_x_neg ? w_scale_zero : (r_px_hi < 32'(BINS_PER_AXIS));
        w_y_ok   = r_y_neg ? w_scale_zero : (r_py_hi < 32'(BINS_PER_AXIS));
        w_acc_ix = r_x_neg ? '0 : r_px_hi[IDX_W-1:0];
        w_acc_iy = r_y_neg ? '0 : r_py_hi[IDX_W-1:0];
        w_rd_ok  = (32'(r_row) < 32'(BINS_PER_AXIS)) && (32'(r_col) < 32'(BINS_PER_AXIS));

        if (r_func == FUNC_READ) begin
            w_ix = IDX_W'(r_row);
            w_iy = IDX_W'(r_col);
            w_ok = w_rd_ok;
            n_bx = r_row;
            n_by = r_col;
        end else begin
            w_ix = w_acc_ix;
            w_iy = w_acc_iy;
            w_ok = w_x_ok && w_y_ok;
            // a skipped point reports bin 0,0
            n_bx = w_ok ? OUT_IDX_W'(w_acc_ix) : '0;
            n_by = w_ok ? OUT_IDX_W'(w_acc_iy) : '0;
        end
        w_addr = ADDR_W'(w_ix) * ADDR_W'(BINS_PER_AXIS) + ADDR_W'(w_iy);
    end

    // saturating increment on the word just read
    always_comb begin
        w_new_count = (r_rd_data == {COUNT_WIDTH{1'b1}}) ? r_rd_data
                                                          : r_rd_data + COUNT_WIDTH'(1);
        if (!r_ok) begin
            w_res_count = '0;
        end else if (r_func == FUNC_ACCUM) begin
            w_res_count = w_new_count;
        end else begin
            w_res_count = r_rd_data;
        end
    end

    // memory port control
    always_comb begin
        w_mem_re    = (r_state == S_ADDR);
        w_mem_we    = 1'b0;
        w_mem_waddr = r_addr;
        w_mem_wdata = w_new_count;
        if (r_state == S_CLEAR) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = r_clr_addr;
            w_mem_wdata = '0;
        end else if (r_state == S_DONE) begin
            w_mem_we = w_out_free && r_ok && (r_func == FUNC_ACCUM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[w_addr];
        end
    end

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin  <= RESET_ORIGIN;
            r_y_origin  <= RESET_ORIGIN;
            r_bin_scale <= RESET_SCALE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_X_ORIGIN:  r_x_origin  <= i_cfg_data;
                CFG_Y_ORIGIN:  r_y_origin  <= i_cfg_data;
                CFG_BIN_SCALE: r_bin_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // in the last step the output register is reloaded below instead
            if (r_out_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_func  <= s_axis_tuser;
                        r_dx    <= n_dx;
                        r_dy    <= n_dy;
                        r_row   <= s_axis_tdata[2*COORD_W+REQ_IDX_W-1:2*COORD_W];
                        r_col   <= s_axis_tdata[S_TDATA_W-1:2*COORD_W+REQ_IDX_W];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_px_hi <= w_px[63:32];
                    r_py_hi <= w_py[63:32];
                    r_x_neg <= r_dx[32];
                    r_y_neg <= r_dy[32];
                    r_state <= S_ADDR;
                end
                S_ADDR: begin
                    r_addr  <= w_addr;
                    r_ok    <= w_ok;
                    r_bx    <= n_bx;
                    r_by    <= n_by;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold here while the previous result is still waiting
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {OUT_COUNT_W'(w_res_count), r_by, r_bx};
                        r_out_ok    <= r_ok;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/tdph_checker.sv
// ----------------------------------------------------------------------------
// tdph_checker: port level checks for the 2d position histogram unit
// watches the stream ports over time, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tdph_checker
    import tdph_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [M_TDATA_W-1:0]  m_axis_tdata,
    input wire logic                  m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a skipped point or bad read reports a zero count
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[OUT_COUNT_LSB+OUT_COUNT_W-1:OUT_COUNT_LSB] == '0)
        else $error("out of range result with nonzero count");

    // the clearing pass blocks input right after reset
    a_clear_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("input taken or result shown during clearing pass");

    // an accepted transaction drops input ready while it is worked on
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transaction");

endmodule

bind two_d_position_histogram_unit tdph_checker u_tdph_checker (.*);

`default_nettype wire

// File: tb/two_d_position_histogram_unit_tb.sv
// ----------------------------------------------------------------------------
// two_d_position_histogram_unit_tb: self-checking bench for the 2d histogram
// drives accumulate and read transactions over the input stream, predicts
// every bin index, range flag and count in a local copy of the histogram, and
// checks each output transaction in order under random idling and back-pressure
// ----------------------------------------------------------------------------
module two_d_position_histogram_unit_tb;
    import tdph_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // index with no register behind it, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int BINS         = BINS_PER_AXIS_DEF;
    localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
    localparam int STALL_LIMIT  = 200000;  // covers the clearing pass
    localparam int DRAIN_CYCLES = 8;       // drain time after the last result
    localparam int ITEMS_PER_GRID = 150;

    // one output transaction as the bench sees it
    typedef struct packed {
        logic [7:0]  bx;
        logic [7:0]  by;
        logic        ok;
        logic [31:0] cnt;
    } t_bin_result;

    // dut ports, the driven ones known from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = FUNC_ACCUM;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_X_ORIGIN;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // local copy of the grid setup and of the count memory
    logic signed [31:0] x_org = RESET_ORIGIN;
    logic signed [31:0] y_org = RESET_ORIGIN;
    logic [31:0]        bin_scale = RESET_SCALE;
    logic [31:0]        hist_counts [0:BINS*BINS-1];

    t_bin_result        pending_bins[$];   // predicted results not yet seen
    logic [15:0]        touched_bins[$];   // recently hit bins, read back later

    // idling knobs: gap and stall in percent of cycles, plus hold-off requests
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int hold_reqs      = 0;

    int fail_cnt    = 0;
    int idle_run    = 0;
    int n_accum     = 0;
    int n_off_grid  = 0;
    int n_reads     = 0;
    int n_checked   = 0;
    int n_grids     = 0;

    two_d_position_histogram_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // x_coord, y_coord, read_row, read_col
        .s_axis_tuser  (s_axis_tuser),   // func
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // bin_x, bin_y, bin_count
        .m_axis_tuser  (m_axis_tuser),   // in_range
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // floor((pos - org) * scale) on one axis; the difference is exact in 33
    // bits and the product exact in 64, only the upper 32 bits matter
    function automatic logic axis_bin(input logic signed [31:0] pos,
                                      input logic signed [31:0] org,
                                      output logic [7:0] idx);
        longint      diff;
        logic [63:0] prod;
        diff = longint'(pos) - longint'(org);
        idx  = '0;
        // below the lower edge only a zero scale still lands in bin 0
        if (diff < 0) return (bin_scale == '0);
        prod = 64'(diff) * {32'b0, bin_scale};
        prod = prod >> 32;
        if (prod >= BINS) return 1'b0;
        idx = prod[7:0];
        return 1'b1;
    endfunction

    // works out one result and updates the local count memory
    function automatic t_bin_result predict_histogram(input logic fn,
                                                      input logic [31:0] xc,
                                                      input logic [31:0] yc,
                                                      input logic [7:0] rr,
                                                      input logic [7:0] rc);
        t_bin_result res;
        logic [7:0]  ix;
        logic [7:0]  iy;
        logic [15:0] addr;
        res = '0;
        if (fn == FUNC_ACCUM) begin
            n_accum++;
            if (axis_bin(xc, x_org, ix) && axis_bin(yc, y_org, iy)) begin
                addr = {ix, iy};
                // saturate at the top of the count range
                if (hist_counts[addr] != '1) hist_counts[addr] += 32'd1;
                res.bx  = ix;
                res.by  = iy;
                res.ok  = 1'b1;
                res.cnt = hist_counts[addr];
                touched_bins = {touched_bins, addr};
                if (touched_bins.size() > 64) void'(touched_bins.pop_front());
            end else begin
                // off-grid point: everything reads back as zero
                n_off_grid++;
            end
        end else begin
            // every 8-bit row and column is inside a 256-bin axis
            n_reads++;
            res.bx  = rr;
            res.by  = rc;
            res.ok  = 1'b1;
            res.cnt = hist_counts[{rr, rc}];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one input transaction; valid stays high on return so back-to-back
    // transactions never lower and raise it in one step
    task automatic send_item(input logic fn, input logic [31:0] xc,
                             input logic [31:0] yc, input logic [7:0] rr,
                             input logic [7:0] rc);
        t_bin_result exp_res;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {rc, rr, yc, xc};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        exp_res      = predict_histogram(fn, xc, yc, rr, rc);
        pending_bins = {pending_bins, exp_res};
    endtask

    // drop valid and wait for every predicted result, plus a few cycles
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_bins.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_X_ORIGIN:  x_org = val;
            CFG_Y_ORIGIN:  y_org = val;
            CFG_BIN_SCALE: bin_scale = val;
            default: ;  // spare index, nothing to track
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_grid(input logic [31:0] xo, input logic [31:0] yo,
                            input logic [31:0] sc);
        wait_idle();
        cfg_write(CFG_X_ORIGIN, xo);
        cfg_write(CFG_Y_ORIGIN, yo);
        cfg_write(CFG_BIN_SCALE, sc);
        n_grids++;
    endtask

    // coordinate that mostly lands on the grid of the current setup
    function automatic logic [31:0] grid_point(input logic [31:0] org);
        longint unsigned span;
        longint unsigned reach;
        if (bin_scale == '0) span = 64'd1 << 20;
        else span = (64'd1 << 40) / bin_scale;
        reach = span + span / 32 + 1;
        if (reach > 64'hFFFF_FFFF) reach = 64'hFFFF_FFFF;
        // hot corner so some bins climb well above one
        if ($urandom_range(0, 99) < 40) reach = reach / 64 + 1;
        // a few just under the lower edge
        if ($urandom_range(0, 99) < 10) return org - $urandom_range(1, 1000);
        return org + $urandom_range(0, reach[31:0]);
    endfunction

    task automatic send_random_item();
        logic [31:0] xc;
        logic [31:0] yc;
        logic [7:0]  rr;
        logic [7:0]  rc;
        logic [15:0] addr;
        xc = $urandom;
        yc = $urandom;
        rr = $urandom;
        rc = $urandom;
        if ($urandom_range(0, 99) < 25) begin
            // read back: mostly a bin that was just hit
            if (touched_bins.size() > 0 && $urandom_range(0, 99) < 60) begin
                addr = touched_bins[$urandom_range(0, touched_bins.size() - 1)];
                rr = addr[15:8];
                rc = addr[7:0];
            end
            send_item(FUNC_READ, xc, yc, rr, rc);
        end else begin
            if ($urandom_range(0, 99) < 85) begin
                xc = grid_point(x_org);
                yc = grid_point(y_org);
            end
            send_item(FUNC_ACCUM, xc, yc, rr, rc);
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset grid: -12.0 origin, 100 bins per unit, edges and reads
    task automatic test_reset_grid();
        logic [31:0] o;
        o = RESET_ORIGIN;
        send_item(FUNC_ACCUM, o, o, 8'h00, 8'h00);                   // bin 0,0
        send_item(FUNC_ACCUM, o, o, 8'hFF, 8'hFF);                   // count 2
        send_item(FUNC_ACCUM, o - 1, o, 8'h00, 8'h00);               // just below
        send_item(FUNC_ACCUM, o + 167772, o + 167772, 8'h00, 8'h00); // last bin
        send_item(FUNC_ACCUM, o + 167773, o, 8'h00, 8'h00);          // one past
        send_item(FUNC_ACCUM, o + 655, o + 656, 8'h00, 8'h00);       // floor on 1.0
        send_item(FUNC_ACCUM, 32'h7FFF_FFFF, 32'h8000_0000, 8'h00, 8'h00);
        send_item(FUNC_READ, 32'h7FFF_FFFF, 32'h8000_0000, 8'h00, 8'h00);
        send_item(FUNC_READ, '0, '0, 8'hFF, 8'hFF);
        send_item(FUNC_READ, '0, '0, 8'h00, 8'h01);
        send_item(FUNC_READ, '1, '1, 8'h00, 8'hFF);                  // never hit
    endtask

    // zero scale folds every point, even below the origin, into bin 0,0
    task automatic test_zero_scale();
        set_grid(RESET_ORIGIN, RESET_ORIGIN, 32'h0);
        send_item(FUNC_ACCUM, 32'h8000_0000, 32'h7FFF_FFFF, 8'h00, 8'h00);
        send_item(FUNC_ACCUM, RESET_ORIGIN - 1, 32'h0, 8'h00, 8'h00);
        send_item(FUNC_READ, '0, '0, 8'h00, 8'h00);
    endtask

    // extreme origins with the largest scale, about one bin per lsb
    task automatic test_extreme_grid();
        set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(FUNC_ACCUM, 32'h8000_0000, 32'h7FFF_FFFF, 8'h00, 8'h00);
        send_item(FUNC_ACCUM, 32'h8000_0100, 32'h7FFF_FFFF, 8'h00, 8'h00);
        send_item(FUNC_ACCUM, 32'h8000_0101, 32'h7FFF_FFFF, 8'h00, 8'h00);
        send_item(FUNC_ACCUM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'h00, 8'h00);
        send_item(FUNC_ACCUM, 32'h8000_0000, 32'h7FFF_FFFE, 8'h00, 8'h00);
    endtask

    // a write to the spare index must leave the grid alone
    task automatic test_spare_register();
        set_grid(RESET_ORIGIN, RESET_ORIGIN, RESET_SCALE);
        cfg_write(CFG_SPARE, 32'hDEAD_BEEF);
        send_item(FUNC_ACCUM, RESET_ORIGIN, RESET_ORIGIN, 8'h00, 8'h00);
    endtask

    // random traffic over several grids, once per idling mode
    task automatic test_random_stream();
        int grid_seq [9] = '{0, 2, 1, 3, 6, 2, 4, 5, 0};
        int sel;
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin send_gap_pct = 35; recv_stall_pct = 56; end
                1: begin send_gap_pct = 56; recv_stall_pct = 35; end
                default: begin send_gap_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int k = 0; k < 3; k++) begin
                sel = grid_seq[mode * 3 + k];
                case (sel)
                    0: set_grid(RESET_ORIGIN, RESET_ORIGIN, RESET_SCALE);
                    1: set_grid('0, '0, 32'h0001_0000);
                    2: set_grid($urandom, $urandom,
                                $urandom_range(32'h0001_0000, 32'h0400_0000));
                    3: set_grid($urandom, $urandom, 32'hFFFF_FFFF);
                    4: set_grid($urandom, $urandom, 32'h0);
                    5: set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h1);
                    default: set_grid($urandom, $urandom, $urandom);
                endcase
                repeat (ITEMS_PER_GRID) send_random_item();
            end
        end
    endtask

    // receiver holds off while the sender keeps offering, input must stall
    task automatic test_backpressure();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        set_grid(RESET_ORIGIN, RESET_ORIGIN, RESET_SCALE);
        hold_reqs++;
        repeat (40) send_random_item();
    endtask

    // ------------------------------------------------------------------------
    // receiver side: random stalls plus the long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : receiver
        int hold_left;
        int seen;
        hold_left = 0;
        seen      = 0;
        forever begin
            @(posedge i_clk);
            if (seen != hold_reqs) begin
                seen      = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker: each output transaction against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_bin_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_bins.size() == 0) begin
                $error("unexpected result: bin_x %0d bin_y %0d in_range %0d bin_count %0d",
                       m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tuser,
                       m_axis_tdata[47:16]);
                fail_cnt++;
            end else begin
                want = pending_bins.pop_front();
                n_checked++;
                if (m_axis_tdata[7:0] !== want.bx) begin
                    $error("bin_x expected %0d got %0d", want.bx, m_axis_tdata[7:0]);
                    fail_cnt++;
                end
                if (m_axis_tdata[15:8] !== want.by) begin
                    $error("bin_y expected %0d got %0d", want.by, m_axis_tdata[15:8]);
                    fail_cnt++;
                end
                if (m_axis_tuser !== want.ok) begin
                    $error("in_range expected %0d got %0d", want.ok, m_axis_tuser);
                    fail_cnt++;
                end
                if (m_axis_tdata[47:16] !== want.cnt) begin
                    $error("bin_count expected %0d got %0d", want.cnt,
                           m_axis_tdata[47:16]);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog: cycles in a row with no transaction on either stream
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", idle_run);
            $display("two_d_position_histogram_unit verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        foreach (hist_counts[i]) hist_counts[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the count memory clears after reset; send_item waits on tready

        test_reset_grid();
        test_zero_scale();
        test_extreme_grid();
        test_spare_register();
        test_random_stream();
        test_backpressure();

        wait_idle();
        $display("covered %0d accumulates (%0d off grid) and %0d reads over %0d grids",
                 n_accum, n_off_grid, n_reads, n_grids);
        $display("%0d results checked under idling, stalls and a long hold-off",
                 n_checked);
        if (fail_cnt == 0)
            $display("two_d_position_histogram_unit verification clean");
        else
            $display("two_d_position_histogram_unit verification failed");
        $finish;
    end

endmodule
